// ----- hw/rtl/multi_led_blink_controller_core_assert.svh -----
// Assertion macros for the RTL file that checks itself (multi_led_blink_controller_core).
`ifndef MULTI_LED_BLINK_CONTROLLER_CORE_ASSERT_SVH
`define MULTI_LED_BLINK_CONTROLLER_CORE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define MLBC_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mlbc assertion failed");

// Next-cycle implication, checked out of reset.
`define MLBC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mlbc assertion failed");

`endif

// ----- hw/rtl/mlbc_pkg.sv -----
package mlbc_pkg;

	localparam int LED_COUNT = 3;
	localparam int LED_W     = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
	localparam int PIN_OUT   = 3;

	typedef logic [2:0]       opcode_t;
	typedef logic [2:0]       mode_t;
	typedef logic [7:0]       count_t;
	typedef logic [LED_W-1:0] led_addr_t;

	localparam opcode_t OP_TICK   = 3'd0;
	localparam opcode_t OP_ON     = 3'd1;
	localparam opcode_t OP_OFF    = 3'd2;
	localparam opcode_t OP_TOGGLE = 3'd3;
	localparam opcode_t OP_BLINK  = 3'd4;
	localparam opcode_t OP_SLOW   = 3'd5;
	localparam opcode_t OP_FAST   = 3'd6;

	localparam mode_t MODE_OFF   = 3'd0;
	localparam mode_t MODE_ON    = 3'd1;
	localparam mode_t MODE_BLINK = 3'd2;
	localparam mode_t MODE_SLOW  = 3'd3;
	localparam mode_t MODE_FAST  = 3'd4;

	localparam logic [1:0] REG_NORMAL = 2'd0;
	localparam logic [1:0] REG_SLOW   = 2'd1;
	localparam logic [1:0] REG_FAST   = 2'd2;

	localparam count_t NORMAL_RST = 8'd5;
	localparam count_t SLOW_RST   = 8'd10;
	localparam count_t FAST_RST   = 8'd2;

	typedef struct packed {
		count_t count;
		logic   toggle;
	} tick_res_t;

endpackage

// ----- hw/rtl/mlbc_tick_unit.sv -----
module mlbc_tick_unit
	import mlbc_pkg::*;
(
	input  mode_t     mode,
	input  count_t    count,
	input  count_t    normal_interval,
	input  count_t    slow_interval,
	input  count_t    fast_interval,
	output tick_res_t res
);

	count_t ival;
	count_t next;

	always_comb begin
		case (mode)
			MODE_SLOW: ival = slow_interval;
			MODE_FAST: ival = fast_interval;
			default:   ival = normal_interval;
		endcase
	end

	// Wrap at eight bits, as the counter does.
	assign next = count + 8'd1;

	always_comb begin
		res.count  = count;
		res.toggle = 1'b0;
		if (mode > MODE_ON) begin
			if (next >= ival) begin
				res.count  = '0;
				res.toggle = 1'b1;
			end else begin
				res.count = next;
			end
		end
	end

endmodule

// ----- hw/rtl/multi_led_blink_controller_core.sv -----
// Channel | Direction | Handshake            | Payload
// in      | input     | in_valid / in_stall  | opcode, led_sel
// out     | output    | out_valid / out_stall| pin_levels, addressed_mode
// cfg     | input     | cfg_we               | cfg_index, cfg_data
//
// A tick steps one LED per cycle through the shared increment-and-compare
// unit, then the result register is loaded in the emit state.
// Any other command goes through the accept, update and result states.
// Reset puts every LED in normal blink, counters at zero and pins dark.
// The result register lets the next transaction be accepted while a result
// waits; the update stalls only if a new result is due and the old one is held.
module multi_led_blink_controller_core
	import mlbc_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_stall,
	input  logic [2:0]   opcode,
	input  logic [3:0]   led_sel,
	output logic         out_valid,
	input  logic         out_stall,
	output logic [2:0]   pin_levels,
	output logic [2:0]   addressed_mode,
	input  logic         cfg_we,
	input  logic [1:0]   cfg_index,
	input  logic [7:0]   cfg_data
);

`include "multi_led_blink_controller_core_assert.svh"

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_TICK = 2'd1;
	localparam logic [1:0] ST_CMD  = 2'd2;
	localparam logic [1:0] ST_EMIT = 2'd3;

	localparam led_addr_t LAST = led_addr_t'(LED_COUNT - 1);

	logic [1:0]     state_q;
	led_addr_t      iter_q;
	opcode_t        op_q;
	led_addr_t      idx_q;
	logic           ok_q;
	count_t         normal_q;
	count_t         slow_q;
	count_t         fast_q;
	mode_t          mode_q  [LED_COUNT];
	count_t         count_q [LED_COUNT];
	logic [LED_COUNT-1:0] pin_q;
	logic           out_valid_q;
	logic [2:0]     pins_out_q;
	mode_t          mode_out_q;

	led_addr_t      addr;
	mode_t          mode_rd;
	count_t         count_rd;
	tick_res_t      tick_res;
	logic           in_acc;
	logic           emit_go;
	logic [2:0]     pins_now;

	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign emit_go  = (state_q == ST_EMIT) && (!out_valid_q || !out_stall);

	assign addr     = (state_q == ST_TICK) ? iter_q : idx_q;
	assign mode_rd  = mode_q[addr];
	assign count_rd = count_q[addr];

	mlbc_tick_unit u_tick (
		.mode            (mode_rd),
		.count           (count_rd),
		.normal_interval (normal_q),
		.slow_interval   (slow_q),
		.fast_interval   (fast_q),
		.res             (tick_res)
	);

	always_comb begin
		pins_now = '0;
		for (int i = 0; i < PIN_OUT; i++) begin
			if (i < LED_COUNT) begin
				pins_now[i] = pin_q[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			normal_q <= NORMAL_RST;
			slow_q   <= SLOW_RST;
			fast_q   <= FAST_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_NORMAL: normal_q <= cfg_data;
				REG_SLOW:   slow_q   <= cfg_data;
				REG_FAST:   fast_q   <= cfg_data;
				default:    ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			iter_q      <= '0;
			op_q        <= OP_TICK;
			idx_q       <= '0;
			ok_q        <= 1'b0;
			out_valid_q <= 1'b0;
			pin_q       <= '0;
			for (int i = 0; i < LED_COUNT; i++) begin
				mode_q[i]  <= MODE_BLINK;
				count_q[i] <= '0;
			end
		end else begin
			if (emit_go) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						op_q    <= opcode;
						idx_q   <= led_sel[LED_W-1:0];
						ok_q    <= ({1'b0, led_sel} < 5'(LED_COUNT));
						iter_q  <= '0;
						state_q <= (opcode == OP_TICK) ? ST_TICK : ST_CMD;
					end
				end
				ST_TICK: begin
					count_q[addr] <= tick_res.count;
					if (tick_res.toggle) begin
						pin_q[addr] <= ~pin_q[addr];
					end
					if (iter_q == LAST) begin
						state_q <= ST_EMIT;
					end else begin
						iter_q <= iter_q + led_addr_t'(1);
					end
				end
				ST_CMD: begin
					if (ok_q) begin
						unique case (op_q)
							OP_ON: begin
								if (mode_rd != MODE_ON) begin
									mode_q[addr] <= MODE_ON;
									pin_q[addr]  <= 1'b1;
								end
							end
							OP_OFF: begin
								if (mode_rd != MODE_OFF) begin
									mode_q[addr] <= MODE_OFF;
									pin_q[addr]  <= 1'b0;
								end
							end
							OP_TOGGLE: pin_q[addr]  <= ~pin_q[addr];
							OP_BLINK:  mode_q[addr] <= MODE_BLINK;
							OP_SLOW:   mode_q[addr] <= MODE_SLOW;
							OP_FAST:   mode_q[addr] <= MODE_FAST;
							default:   ;
						endcase
					end
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					// Hold until the result register is free.
					if (emit_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (emit_go) begin
			pins_out_q <= pins_now;
			mode_out_q <= ok_q ? mode_rd : MODE_OFF;
		end
	end

	assign out_valid      = out_valid_q;
	assign pin_levels     = pins_out_q;
	assign addressed_mode = mode_out_q;

	`MLBC_ASSERT_NEXT(a_accept_leaves_idle, in_acc, state_q != ST_IDLE)
	`MLBC_ASSERT_NEXT(a_emit_loads, emit_go, out_valid_q && (state_q == ST_IDLE))
	`MLBC_ASSERT_NOW(a_iter_in_range, state_q == ST_TICK, iter_q <= LAST)
	`MLBC_ASSERT_NOW(a_mode_legal, state_q == ST_EMIT && ok_q, mode_rd <= MODE_FAST)

endmodule
